// ----- src/shabs_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Used by shabs_sched, shabs_core and sha256_byte_stream_hasher_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shabs_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] chain_t;

    // input action codes
    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // block geometry
    localparam logic [5:0] LEN_POS   = 6'd56;  // first byte of the length field
    localparam logic [5:0] LAST_POS  = 6'd63;  // last byte of a block
    localparam logic [5:0] LAST_RND  = 6'd63;  // last compression round
    localparam logic [2:0] LAST_IDX  = 3'd7;   // last digest word
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    // compression core controls
    typedef struct packed {
        logic init;     // load working vars from chain
        logic round;    // run one round
        logic fold;     // add working vars into chain
        logic restart;  // chain back to initial hash
    } core_ctrl_t;

    // message window controls
    typedef struct packed {
        logic shift_byte;  // shift one message/pad byte in
        logic step;        // advance schedule by one word
    } sched_ctrl_t;

    localparam word_t INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sigma0: rotr 2, 13, 22
    function automatic word_t big_sig0(input word_t x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Sigma1: rotr 6, 11, 25
    function automatic word_t big_sig1(input word_t x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // sigma0: rotr 7, 18, shr 3
    function automatic word_t small_sig0(input word_t x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // sigma1: rotr 17, 19, shr 10
    function automatic word_t small_sig1(input word_t x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ----- src/sha256_byte_stream_hasher_top.sv -----
// SHA-256 byte-stream hasher: sequencer, length tracking and digest output.
// Depends on shabs_pkg, shabs_sched and shabs_core.
//
// Takes one message byte per word on the input channel (action 0) or a finish
// request (action 1), and after a finish returns the eight digest words H0..H7
// on the output channel, then starts a fresh message. An absorbed byte shifts
// into the message window; the byte that completes a 64-byte block then runs
// the 64 rounds on the single round unit and a fold into the chaining state.
// A finish pads the pending block with (64 - pending) bytes and compresses it,
// with a further padding block and compression when 56 or more bytes are
// pending, then returns one digest word per cycle while the receiver does not
// stall. in_stall is high whenever the block is not idle.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         action,
    input  wire  [7:0]  byte_value,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shabs_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] bits_reg;
    logic [63:0] bits_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [5:0]  rnd_reg;
    logic [5:0]  rnd_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        pad_first_reg;
    logic        pad_first_next;
    logic        last_blk_reg;
    logic        last_blk_next;
    logic        finishing_reg;
    logic        finishing_next;

    logic        in_acc;
    logic        out_acc;
    logic [7:0]  sched_byte;
    sched_ctrl_t sched_ctrl;
    core_ctrl_t  core_ctrl;
    word_t       w_cur;
    chain_t      chain;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // message window / schedule
    shabs_sched u_sched (
        .clk     (clk),
        .ctrl    (sched_ctrl),
        .byte_in (sched_byte),
        .w_out   (w_cur)
    );

    // round unit and chaining state
    shabs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .w_in  (w_cur),
        .k_in  (ROUND_K[rnd_reg]),
        .chain (chain)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (fill_reg == LAST_POS)
                    begin
                        state_next = ST_COMP;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (rnd_reg == LAST_RND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_blk_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_acc && idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        sched_ctrl     = '0;
        core_ctrl      = '0;
        sched_byte     = byte_value;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        pad_first_next = pad_first_reg;
        last_blk_next  = last_blk_reg;
        finishing_next = finishing_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_acc)
                begin
                    if (action == ACT_FINISH)
                    begin
                        // message length in bits
                        len_next       = bits_reg + {55'b0, fill_reg, 3'b000};
                        pad_first_next = 1'b1;
                        last_blk_next  = (fill_reg < LEN_POS);
                        finishing_next = 1'b1;
                    end
                    else
                    begin
                        sched_ctrl.shift_byte = 1'b1;
                        fill_next             = fill_reg + 6'd1;
                        finishing_next        = 1'b0;
                        if (fill_reg == LAST_POS)
                        begin
                            core_ctrl.init = 1'b1;
                            rnd_next       = '0;
                            bits_next      = bits_reg + BLOCK_BITS;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                // marker, zeros, then big-endian length in the final block
                sched_ctrl.shift_byte = 1'b1;
                pad_first_next        = 1'b0;
                if (pad_first_reg)
                begin
                    sched_byte = PAD_MARK;
                end
                else if (last_blk_reg && fill_reg >= LEN_POS)
                begin
                    sched_byte = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                end
                else
                begin
                    sched_byte = 8'h00;
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    core_ctrl.init = 1'b1;
                    rnd_next       = '0;
                end
            end
            ST_COMP:
            begin
                core_ctrl.round  = 1'b1;
                sched_ctrl.step  = 1'b1;
                rnd_next         = rnd_reg + 6'd1;
            end
            ST_FOLD:
            begin
                core_ctrl.fold = 1'b1;
                if (finishing_reg)
                begin
                    last_blk_next = 1'b1;
                    idx_next      = '0;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        core_ctrl.restart = 1'b1;
                        fill_next         = '0;
                        bits_next         = '0;
                        finishing_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // digest word straight from the chaining registers
    assign digest_word = chain[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            pad_first_reg <= 1'b0;
            last_blk_reg  <= 1'b0;
            finishing_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            pad_first_reg <= pad_first_next;
            last_blk_reg  <= last_blk_next;
            finishing_reg <= finishing_next;
        end
    end

    // length shifter is payload
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

`default_nettype wire

// ----- src/shabs_sched.sv -----
// Message window: 64-byte block buffer that doubles as the 16-word schedule window.
// Depends on shabs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shabs_sched (
    input  wire                      clk,
    input  wire shabs_pkg::sched_ctrl_t ctrl,
    input  wire [7:0]                byte_in,
    output shabs_pkg::word_t         w_out
);
    import shabs_pkg::*;

    // word i sits at [511-32i -: 32]; word 0 is the oldest
    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_new;

    // next schedule word from the current window
    always_comb
    begin
        w_new = win_reg[511:480] + small_sig0(win_reg[479:448])
              + win_reg[223:192] + small_sig1(win_reg[63:32]);
    end

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.shift_byte)
        begin
            win_next = {win_reg[503:0], byte_in};
        end
        else if (ctrl.step)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    // buffer contents need no reset
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign w_out = win_reg[511:480];

endmodule

`default_nettype wire

// ----- src/shabs_core.sv -----
// Compression core: one SHA-256 round per cycle plus the chaining-state fold.
// Depends on shabs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shabs_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire shabs_pkg::core_ctrl_t ctrl,
    input  wire shabs_pkg::word_t   w_in,
    input  wire shabs_pkg::word_t   k_in,
    output shabs_pkg::chain_t       chain
);
    import shabs_pkg::*;

    chain_t v_reg;
    chain_t v_next;
    chain_t chain_reg;
    chain_t chain_next;
    word_t  t1;
    word_t  t2;
    word_t  choose;
    word_t  major;

    // round function: v[0]=a ... v[7]=h
    always_comb
    begin
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + big_sig1(v_reg[4]) + choose + k_in + w_in;
        t2 = big_sig0(v_reg[0]) + major;
    end

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.init)
        begin
            v_next = chain_reg;
        end
        else if (ctrl.round)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // chaining state update
    always_comb
    begin
        chain_next = chain_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (ctrl.restart)
            begin
                chain_next[i] = INIT_HASH[i];
            end
            else if (ctrl.fold)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for sha256_byte_stream_hasher_top: hashes random byte messages
// and checks every digest word against a built-in SHA-256 predictor.
// Depends on shabs_pkg (action codes and pad marker) and the hasher RTL.
`timescale 1ns / 1ps

module tb_top;
    import shabs_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int CALM_TAIL   = 60;    // no idling once fewer than this many input words remain
    localparam int TAIL_CYCLES = 200;
    localparam int LONG_HOLD   = 600;

    typedef struct {
        logic       act;
        logic [7:0] val;
        bit         wait_drain;  // hold this word back until all digests are out
    } msg_word_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_exp_t;

    localparam logic [31:0] sha_iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] sha_k [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_byte_stream_hasher_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // predictor state
    logic [31:0] hash_st [8];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  fill;
    logic [63:0] bits_done;

    msg_word_t   byte_feed [$];
    digest_exp_t digest_due [$];

    bit failed;
    bit in_took;
    bit in_bursty;
    bit out_bursty;
    bit held_long;
    int in_gap;
    int out_gap;
    int hold_left;
    int words_seen;
    int quiet_cycles;

    always #10 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_bytes into hash_st
    function automatic void sha_compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = hash_st[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_st[i] = hash_st[i] + v[i];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_st[i] = sha_iv[i];
        fill = '0;
        bits_done = '0;
    endfunction

    // absorb a byte, or pad, close the message and queue its eight digest words
    function automatic void hash_step(input logic act, input logic [7:0] b);
        logic [63:0] len_bits;
        int          p;
        digest_exp_t d;
        if (act == ACT_ABSORB)
        begin
            blk_bytes[fill] = b;
            fill = fill + 6'd1;
            if (fill == 6'd0)
            begin
                sha_compress_block();
                bits_done = bits_done + 64'd512;
            end
        end
        else
        begin
            len_bits = bits_done + {55'd0, fill, 3'b000};
            p = fill;
            blk_bytes[p] = PAD_MARK;
            p++;
            // length field no longer fits: pad out and spend an extra block
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk_bytes[p] = 8'h00;
                    p++;
                end
                sha_compress_block();
                p = 0;
            end
            while (p < 56)
            begin
                blk_bytes[p] = 8'h00;
                p++;
            end
            for (int k = 0; k < 8; k++)
                blk_bytes[56 + k] = len_bits[63 - 8*k -: 8];
            sha_compress_block();
            for (int k = 0; k < 8; k++)
            begin
                d.word = hash_st[k];
                d.idx  = 3'(k);
                d.last = (k == 7);
                digest_due.push_back(d);
            end
            restart_hash();
        end
    endfunction

    // queue one message of random bytes followed by its finish word
    task automatic add_message(input int len, input bit drain_first);
        msg_word_t m;
        for (int i = 0; i <= len; i++)
        begin
            m.act = (i == len) ? ACT_FINISH : ACT_ABSORB;
            m.val = 8'($urandom_range(0, 255));
            m.wait_drain = drain_first && (i == 0);
            byte_feed.push_back(m);
        end
    endtask

    task automatic add_word(input logic act, input logic [7:0] val);
        msg_word_t m;
        m.act = act;
        m.val = val;
        m.wait_drain = 1'b0;
        byte_feed.push_back(m);
    endtask

    // input side: note each accepted word and run it through the predictor
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
        begin
            hash_step(action, byte_value);
            void'(byte_feed.pop_front());
        end
    end

    // driver: present words at the falling edge, hold a word until it is taken
    always @(negedge clk)
    begin : drive_blk
        logic drive;
        drive = 1'b0;
        if ($urandom_range(0, 49) == 0)
            in_bursty = !in_bursty;
        if (!rst_n)
            drive = 1'b0;
        else if (in_valid && !in_took)
            drive = 1'b1;
        else if (in_gap > 0)
            in_gap--;
        else if (byte_feed.size() != 0 &&
                 !(byte_feed[0].wait_drain && digest_due.size() != 0))
        begin
            if (in_bursty && byte_feed.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                in_gap = $urandom_range(0, 18);
            else
                drive = 1'b1;
        end
        in_valid <= drive;
        if (drive)
        begin
            action     <= byte_feed[0].act;
            byte_value <= byte_feed[0].val;
        end
    end

    // receiver stall: random bursts, plus one long hold-off while results wait
    always @(negedge clk)
    begin : stall_blk
        logic hold;
        if ($urandom_range(0, 49) == 0)
            out_bursty = !out_bursty;
        if (!held_long && words_seen >= 40 && out_valid)
        begin
            hold_left = LONG_HOLD;
            held_long = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            hold = 1'b1;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            hold = 1'b1;
        end
        else if (out_bursty && byte_feed.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            out_gap = $urandom_range(0, 18);
            hold = 1'b1;
        end
        else
            hold = 1'b0;
        out_stall <= hold;
    end

    // monitor: compare each digest word with the oldest expectation
    always @(posedge clk)
    begin : mon_blk
        digest_exp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (digest_due.size() == 0)
            begin
                $error("digest word %h with no digest pending", digest_word);
                failed = 1'b1;
            end
            else
            begin
                e = digest_due.pop_front();
                if (digest_word !== e.word)
                begin
                    $error("digest_word: expected %h, actual %h", e.word, digest_word);
                    failed = 1'b1;
                end
                if (word_index !== e.idx)
                begin
                    $error("word_index: expected %0d, actual %0d", e.idx, word_index);
                    failed = 1'b1;
                end
                if (last_word !== e.last)
                begin
                    $error("last_word: expected %0d, actual %0d", e.last, last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run_blk
        int r;
        int len;
        int boundary_len [10];
        boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_ABSORB;
        byte_value = 8'h00;
        out_stall = 1'b0;
        failed = 1'b0;
        in_took = 1'b0;
        in_bursty = 1'b1;
        out_bursty = 1'b1;
        held_long = 1'b0;
        in_gap = 0;
        out_gap = 0;
        hold_left = 0;
        words_seen = 0;
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;
        restart_hash();

        // directed: empty message (ignored byte all ones), "abc", byte extremes,
        // back-to-back empty messages
        add_word(ACT_FINISH, 8'hff);
        add_word(ACT_ABSORB, 8'h61);
        add_word(ACT_ABSORB, 8'h62);
        add_word(ACT_ABSORB, 8'h63);
        add_word(ACT_FINISH, 8'h00);
        add_word(ACT_ABSORB, 8'hff);
        add_word(ACT_ABSORB, 8'h00);
        add_word(ACT_ABSORB, 8'h80);
        add_word(ACT_FINISH, 8'h5a);
        add_word(ACT_FINISH, 8'h00);
        add_word(ACT_FINISH, 8'ha5);

        // padding boundaries: last length that fits, first that needs an extra block,
        // exactly one full block
        add_message(55, 1'b1);
        add_message(56, 1'b0);
        add_message(64, 1'b1);

        // random messages, mostly short, some around block boundaries
        while (byte_feed.size() < 380)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                len = $urandom_range(0, 12);
            else if (r < 7)
                len = boundary_len[$urandom_range(0, 9)];
            else
                len = $urandom_range(13, 40);
            add_message(len, $urandom_range(0, 11) == 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_feed.size() != 0 || digest_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
